[rtl/rfd_pkg.sv]
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the radar frame TLV deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

   // result event codes
   localparam logic [2:0] EV_FRAME_HDR  = 3'd0;
   localparam logic [2:0] EV_TLV_HDR    = 3'd1;
   localparam logic [2:0] EV_PAYLOAD    = 3'd2;
   localparam logic [2:0] EV_BAD_LEN    = 3'd3;
   localparam logic [2:0] EV_HDR_OVRUN  = 3'd4;
   localparam logic [2:0] EV_PAY_OVRUN  = 3'd5;

   localparam logic [5:0]  HDR_BYTES     = 6'd40;   // frame header incl. magic word
   localparam int          REC_HDR_BYTES = 8;       // TLV type + length
   localparam logic [15:0] MAX_LEN_RESET = 16'd16384;
   localparam logic [7:0]  SYNC_FIRST    = 8'h02;

   // result queue
   localparam int          RQ_DEPTH = 4;
   localparam int          RQ_PTR_W = 2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_MAGIC,
      PH_HEADER,
      PH_RHDR,
      PH_RPAY,
      PH_RPAD,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] frame_number;
      logic [31:0] tlv_count;
      logic [31:0] object_count;
      logic [31:0] packet_length;
      logic [31:0] record_type;
      logic [31:0] record_length;
      logic [15:0] record_offset;
      logic [7:0]  payload_byte;
      logic        last_of_record;
      logic        end_of_frame;
      logic        last_of_run;
   } rsp_item_type;

   // results of one byte, handed to the queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef struct packed {
      logic       room;    // space for two more items
      logic [2:0] level;
   } q_stat_type;

   // magic word 02 01 04 03 06 05 08 07
   function automatic logic [7:0] sync_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h02;
         3'd1: b = 8'h01;
         3'd2: b = 8'h04;
         3'd3: b = 8'h03;
         3'd4: b = 8'h06;
         3'd5: b = 8'h05;
         3'd6: b = 8'h08;
         3'd7: b = 8'h07;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/rfd_core.sv]
// ----------------------------------------------------------------------------
// rfd_core
// Input register, deframing state and per-byte result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_core
   import rfd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_link_byte,
   input  wire logic        csr_valid,
   input  wire logic [15:0] csr_max_frame_len,
   input  wire q_stat_type  q_stat,
   output      push_type    push
);

   localparam logic [LENGTH_WIDTH-1:0] REC_HDR_LEN = LENGTH_WIDTH'(REC_HDR_BYTES);

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    fire;

   // deframing state
   logic [15:0]             max_len_ff;
   phase_type               phase_ff, phase_in;
   logic [5:0]              bc_ff, bc_in;
   logic                    mm_ff, mm_in;
   logic [31:0]             header_ff [4];
   logic [31:0]             header_in [4];
   logic [LENGTH_WIDTH-1:0] pl_ff, pl_in;
   logic [LENGTH_WIDTH-1:0] pp_ff, pp_in;
   logic [31:0]             recs_ff, recs_in;
   logic [63:0]             rec_hdr_ff, rec_hdr_in;
   logic [31:0]             rec_left_ff, rec_left_in;
   logic [1:0]              pad_ff, pad_in;

   // shared decode
   logic [7:0]              b;
   logic [LENGTH_WIDTH-1:0] pl_dec, pp_inc;
   logic [31:0]             recs_dec, rec_left_dec;
   logic [63:0]             rec_hdr_upd;
   logic [5:0]              bc_inc;
   logic                    sync_ok;
   logic                    hdr_done, len_bad;
   logic [31:0]             pkt_diff;
   logic                    rhdr_done, rlen_over, rlen_zero;
   logic                    pay_last;
   logic [1:0]              pad_raw, pad_clip, pad_dec;
   logic [31:0]             sr_recs;
   logic [LENGTH_WIDTH-1:0] sr_left, sr_pos;
   logic                    sr_go, sr_ovr, take_sr;
   phase_type               sr_phase;

   function automatic logic [15:0] off16(input logic [LENGTH_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic rsp_item_type mk_item(input logic [2:0] ev, input logic [31:0] rt,
                                            input logic [31:0] rl, input logic [15:0] off,
                                            input logic [7:0] pb, input logic last);
      rsp_item_type it;
      it                = '0;
      it.event_res      = ev;
      it.frame_number   = header_ff[1];
      it.tlv_count      = header_ff[3];
      it.object_count   = header_ff[2];
      it.packet_length  = header_ff[0];
      it.record_type    = rt;
      it.record_length  = rl;
      it.record_offset  = off;
      it.payload_byte   = pb;
      it.last_of_record = last;
      return it;
   endfunction

   assign fire      = in_valid_ff && q_stat.room;
   assign req_ready = !in_valid_ff || fire;
   assign b         = in_byte_ff;

   // ---------------------------------------------------------------- decode
   always_comb begin
      pl_dec       = pl_ff - LENGTH_WIDTH'(1);
      pp_inc       = pp_ff + LENGTH_WIDTH'(1);
      recs_dec     = recs_ff - 32'd1;
      rec_left_dec = rec_left_ff - 32'd1;
      bc_inc       = bc_ff + 6'd1;
      sync_ok      = (b == sync_byte(bc_ff[2:0]));

      rec_hdr_upd = rec_hdr_ff;
      rec_hdr_upd[{bc_ff[2:0], 3'b000} +: 8] = b;

      hdr_done = (bc_ff == HDR_BYTES - 6'd1);
      pkt_diff = header_ff[0] - 32'(HDR_BYTES);
      len_bad  = (header_ff[0] < 32'(HDR_BYTES)) || (header_ff[0] > 32'(max_len_ff))
                 || ((({1'b0, pkt_diff}) >> LENGTH_WIDTH) != 33'd0);

      rhdr_done = (bc_ff[2:0] == 3'd7);
      rlen_over = (rec_hdr_upd[63:32] > 32'(pl_dec));
      rlen_zero = (rec_hdr_upd[63:32] == 32'd0);

      pay_last = (rec_left_dec == 32'd0);
      // pad to a multiple of 4, never beyond the payload end
      pad_raw  = 2'd0 - rec_hdr_ff[33:32];
      pad_clip = (LENGTH_WIDTH'(pad_raw) > pl_dec) ? pl_dec[1:0] : pad_raw;
      pad_dec  = pad_ff - 2'd1;

      // next-record check, evaluated on the values left after this byte
      case (phase_ff)
         PH_HEADER: begin
            sr_recs = header_ff[3];
            sr_left = pkt_diff[LENGTH_WIDTH-1:0];
            sr_pos  = '0;
         end
         PH_RHDR: begin
            sr_recs = recs_dec;
            sr_left = pl_dec;
            sr_pos  = pp_inc;
         end
         default: begin
            sr_recs = recs_ff;
            sr_left = pl_dec;
            sr_pos  = pp_inc;
         end
      endcase
      sr_go    = (sr_recs != 32'd0) && (sr_left >= REC_HDR_LEN);
      sr_ovr   = (sr_recs != 32'd0) && !sr_go;
      sr_phase = sr_go ? PH_RHDR : ((sr_left != '0) ? PH_SKIP : PH_HUNT);

      case (phase_ff)
         PH_HEADER: take_sr = hdr_done && !len_bad;
         PH_RHDR:   take_sr = rhdr_done && !rlen_over && rlen_zero;
         PH_RPAY:   take_sr = pay_last && (pad_clip == 2'd0);
         PH_RPAD:   take_sr = (pad_dec == 2'd0) || (pl_dec == '0);
         default:   take_sr = 1'b0;
      endcase
   end

   // ---------------------------------------------------------- datapath next
   always_comb begin
      bc_in       = bc_ff;
      mm_in       = mm_ff;
      header_in   = header_ff;
      pl_in       = pl_ff;
      pp_in       = pp_ff;
      recs_in     = recs_ff;
      rec_hdr_in  = rec_hdr_ff;
      rec_left_in = rec_left_ff;
      pad_in      = pad_ff;

      case (phase_ff)
         PH_HUNT: begin
            if (b == SYNC_FIRST) begin
               bc_in = 6'd1;
               mm_in = 1'b0;
            end
         end
         PH_MAGIC: begin
            if (!sync_ok) mm_in = 1'b1;
            bc_in = bc_inc;
         end
         PH_HEADER: begin
            // little-endian header words at byte offsets 12, 20, 28, 32
            case (bc_ff[5:2])
               4'd3:    header_in[0][{bc_ff[1:0], 3'b000} +: 8] = b;
               4'd5:    header_in[1][{bc_ff[1:0], 3'b000} +: 8] = b;
               4'd7:    header_in[2][{bc_ff[1:0], 3'b000} +: 8] = b;
               4'd8:    header_in[3][{bc_ff[1:0], 3'b000} +: 8] = b;
               default: ;
            endcase
            bc_in = bc_inc;
            if (hdr_done && !len_bad) begin
               pl_in   = pkt_diff[LENGTH_WIDTH-1:0];
               pp_in   = '0;
               recs_in = header_ff[3];
            end
         end
         PH_RHDR: begin
            rec_hdr_in = rec_hdr_upd;
            bc_in      = bc_inc;
            pl_in      = pl_dec;
            pp_in      = pp_inc;
            if (rhdr_done) begin
               recs_in = recs_dec;
               if (!rlen_over) begin
                  if (rlen_zero) pad_in = 2'd0;
                  else rec_left_in = rec_hdr_upd[63:32];
               end
            end
         end
         PH_RPAY: begin
            pl_in       = pl_dec;
            pp_in       = pp_inc;
            rec_left_in = rec_left_dec;
            if (pay_last) pad_in = pad_clip;
         end
         PH_RPAD: begin
            pl_in  = pl_dec;
            pp_in  = pp_inc;
            pad_in = take_sr ? 2'd0 : pad_dec;
         end
         PH_SKIP: begin
            pl_in = pl_dec;
            pp_in = pp_inc;
         end
         default: ;
      endcase

      if (take_sr && sr_go) begin
         bc_in      = 6'd0;
         rec_hdr_in = '0;
      end
   end

   // -------------------------------------------------------------- next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (b == SYNC_FIRST) phase_in = PH_MAGIC;
         end
         PH_MAGIC: begin
            if (bc_ff == 6'd7) phase_in = (mm_ff || !sync_ok) ? PH_HUNT : PH_HEADER;
         end
         PH_HEADER: begin
            if (hdr_done) phase_in = len_bad ? PH_HUNT : sr_phase;
         end
         PH_RHDR: begin
            if (rhdr_done) begin
               if (rlen_over)      phase_in = (pl_dec != '0) ? PH_SKIP : PH_HUNT;
               else if (rlen_zero) phase_in = sr_phase;
               else                phase_in = PH_RPAY;
            end
         end
         PH_RPAY: begin
            if (pay_last)            phase_in = (pad_clip != 2'd0) ? PH_RPAD : sr_phase;
            else if (pl_dec == '0)   phase_in = PH_HUNT;
         end
         PH_RPAD: begin
            if (take_sr) phase_in = sr_phase;
         end
         PH_SKIP: begin
            if (pl_dec == '0) phase_in = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // ----------------------------------------------------------------- results
   always_comb begin
      logic [1:0]   n;
      rsp_item_type s [2];
      logic         eof;

      n    = 2'd0;
      s[0] = '0;
      s[1] = '0;
      eof  = (sr_left == '0);

      case (phase_ff)
         PH_HEADER: begin
            if (hdr_done) begin
               if (len_bad) begin
                  s[0] = mk_item(EV_BAD_LEN, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0);
                  n    = 2'd1;
               end else begin
                  s[0] = mk_item(EV_FRAME_HDR, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0);
                  n    = 2'd1;
               end
            end
         end
         PH_RHDR: begin
            if (rhdr_done) begin
               s[0] = mk_item(EV_TLV_HDR, rec_hdr_upd[31:0], rec_hdr_upd[63:32],
                              off16(pp_inc), 8'd0, 1'b0);
               n    = 2'd1;
               if (rlen_over) begin
                  s[1] = mk_item(EV_PAY_OVRUN, rec_hdr_upd[31:0], rec_hdr_upd[63:32],
                                 off16(pp_inc), 8'd0, 1'b0);
                  n    = 2'd2;
               end
            end
         end
         PH_RPAY: begin
            s[0] = mk_item(EV_PAYLOAD, rec_hdr_ff[31:0], rec_hdr_ff[63:32],
                           off16(pp_ff), b, pay_last);
            n    = 2'd1;
         end
         default: ;
      endcase

      // header of the next record does not fit
      if (take_sr && sr_ovr) begin
         s[n[0]] = mk_item(EV_HDR_OVRUN, 32'd0, 32'd0, off16(sr_pos), 8'd0, 1'b0);
         n       = n + 2'd1;
      end

      if (eof) begin
         s[0].end_of_frame = (s[0].event_res != EV_BAD_LEN);
         s[1].end_of_frame = (s[1].event_res != EV_BAD_LEN);
      end
      if (n == 2'd2)      s[1].last_of_run = 1'b1;
      else if (n == 2'd1) s[0].last_of_run = 1'b1;

      push.count = fire ? n : 2'd0;
      push.item0 = s[0];
      push.item1 = s[1];
   end

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         max_len_ff  <= MAX_LEN_RESET;
         phase_ff    <= PH_HUNT;
         bc_ff       <= '0;
         mm_ff       <= 1'b0;
         header_ff   <= '{default: '0};
         pl_ff       <= '0;
         pp_ff       <= '0;
         recs_ff     <= '0;
         rec_hdr_ff  <= '0;
         rec_left_ff <= '0;
         pad_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid) max_len_ff <= csr_max_frame_len;
         if (fire) begin
            phase_ff    <= phase_in;
            bc_ff       <= bc_in;
            mm_ff       <= mm_in;
            header_ff   <= header_in;
            pl_ff       <= pl_in;
            pp_ff       <= pp_in;
            recs_ff     <= recs_in;
            rec_hdr_ff  <= rec_hdr_in;
            rec_left_ff <= rec_left_in;
            pad_ff      <= pad_in;
         end
      end
   end

   always_comb begin
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (fire)              in_valid_in = 1'b0;
      else                        in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_link_byte;
   end

endmodule

`default_nettype wire

[rtl/rfd_rsp_queue.sv]
// ----------------------------------------------------------------------------
// rfd_rsp_queue
// Four-entry result queue; takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_rsp_queue
   import rfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire push_type     push,
   output      q_stat_type   q_stat,
   output      logic         out_valid,
   input  wire logic         out_ready,
   output      rsp_item_type out_item
);

   rsp_item_type         slot_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  head_ff, head_in;
   logic [RQ_PTR_W-1:0]  tail_ff, tail_in;
   logic [2:0]           level_ff, level_in;
   logic                 pop;

   assign out_valid = (level_ff != 3'd0);
   assign out_item  = slot_ff[head_ff];
   assign pop       = out_valid && out_ready;

   assign q_stat.room  = (level_ff <= 3'(RQ_DEPTH - 2));
   assign q_stat.level = level_ff;

   always_comb begin
      head_in  = head_ff + RQ_PTR_W'(pop);
      tail_in  = tail_ff + RQ_PTR_W'(push.count);
      level_in = level_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) slot_ff[tail_ff] <= push.item0;
      if (push.count == 2'd2) slot_ff[tail_ff + RQ_PTR_W'(1)] <= push.item1;
   end

endmodule

`default_nettype wire

[rtl/radar_frame_tlv_deframer_top.sv]
// ----------------------------------------------------------------------------
// radar_frame_tlv_deframer_top
// Byte-serial deframer for magic-word framed radar packets with TLV records.
// ----------------------------------------------------------------------------
// One link byte is taken per cycle while the queue has room. A byte passes an
// input register, is decoded against the frame state and its results (none,
// one or two) enter a four-entry result queue; rsp_ shows its head. The queue
// port gives one result per cycle while rsp_ready is high, so of a byte that
// makes two results (frame header, record header or last payload byte plus
// header overrun, record header plus payload overrun) the second leaves after
// the first; with a waiting sink the input stalls once the queue holds more
// than two items. The frame length limit must be written through csr_ while
// the block is idle, which the block does not enforce; it resets to 16384.
`default_nettype none

module radar_frame_tlv_deframer_top
   import rfd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_link_byte,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_event_res,
   output      logic [31:0] rsp_frame_number,
   output      logic [31:0] rsp_tlv_count,
   output      logic [31:0] rsp_object_count,
   output      logic [31:0] rsp_packet_length,
   output      logic [31:0] rsp_record_type,
   output      logic [31:0] rsp_record_length,
   output      logic [15:0] rsp_record_offset,
   output      logic [7:0]  rsp_payload_byte,
   output      logic        rsp_last_of_record,
   output      logic        rsp_end_of_frame,
   output      logic        rsp_last_of_run,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_max_frame_len
);

   push_type     push;
   q_stat_type   q_stat;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;

   rfd_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_link_byte     (req_link_byte),
      .csr_valid         (csr_valid),
      .csr_max_frame_len (csr_max_frame_len),
      .q_stat            (q_stat),
      .push              (push)
   );

   rfd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_stat    (q_stat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_event_res      = rsp_item.event_res;
   assign rsp_frame_number   = rsp_item.frame_number;
   assign rsp_tlv_count      = rsp_item.tlv_count;
   assign rsp_object_count   = rsp_item.object_count;
   assign rsp_packet_length  = rsp_item.packet_length;
   assign rsp_record_type    = rsp_item.record_type;
   assign rsp_record_length  = rsp_item.record_length;
   assign rsp_record_offset  = rsp_item.record_offset;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_last_of_record = rsp_item.last_of_record;
   assign rsp_end_of_frame   = rsp_item.end_of_frame;
   assign rsp_last_of_run    = rsp_item.last_of_run;

   // a byte is decoded only when two queue entries are free
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (q_stat.level <= 3'd2))
      else $error("result pushed without queue room");

   a_level: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= 3'(RQ_DEPTH))
      else $error("result queue level out of range");

   a_bad_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_BAD_LEN)) |-> (!rsp_end_of_frame && rsp_last_of_run))
      else $error("bad length item flags wrong");

   a_last_rec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_record) |-> (rsp_event_res == EV_PAYLOAD))
      else $error("record end flag on a non-payload item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

`default_nettype wire

[verif/radar_frame_tlv_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_frame_tlv_deframer testbench
// Feeds link bytes (sync words, frame headers, TLV records, noise, broken and
// bad-length frames) under several length limits and flow-control patterns,
// and checks every result against a cycle-free model of the deframer.
// ----------------------------------------------------------------------------

module testbench;
   import rfd_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LEN_W          = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [63:0] SYNC_WORD = 64'h0708_0506_0304_0102;   // byte 0 first

   localparam int NUM_PHASES  = 5;
   localparam int PRESSURE_PH = 4;
   localparam logic [15:0] PH_LIMIT [NUM_PHASES] = '{16'hFFFF, 16'd40, 16'd120, 16'd0,
                                                     16'd16384};
   localparam int PH_SEND_IDLE [NUM_PHASES] = '{0, 56, 0, 13, 13};
   localparam int PH_STALL     [NUM_PHASES] = '{0, 0, 56, 13, 13};
   localparam int PH_BYTES     [NUM_PHASES] = '{40, 40, 60, 30, 120};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_link_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_frame_number;
   logic [31:0] rsp_tlv_count;
   logic [31:0] rsp_object_count;
   logic [31:0] rsp_packet_length;
   logic [31:0] rsp_record_type;
   logic [31:0] rsp_record_length;
   logic [15:0] rsp_record_offset;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_record;
   logic        rsp_end_of_frame;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_frame_len = 16'd0;

   logic [7:0]   link_q [$];      // bytes waiting to go out on the link
   rsp_item_type result_q [$];    // predicted results, oldest first
   rsp_item_type step_res [$];    // results of the byte being decoded
   logic [7:0]   body [$];        // payload of the frame under construction
   int           body_recs;
   int           queued = 0;
   int           errors = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           cur_phase = -1;
   logic         hold_on = 1'b0;
   logic [15:0]  len_limit = MAX_LEN_RESET;

   // deframer state as seen by the predictor
   phase_type        st_phase = PH_HUNT;
   logic [5:0]       st_count = '0;
   logic             st_mismatch = 1'b0;
   logic [31:0]      st_hdr [4] = '{default: '0};   // length, frame, objects, tlvs
   logic [LEN_W-1:0] st_pay_left = '0;
   logic [LEN_W-1:0] st_pay_pos = '0;
   logic [31:0]      st_recs_left = '0;
   logic [63:0]      st_rec_hdr = '0;
   logic [31:0]      st_rec_left = '0;
   logic [1:0]       st_pad_left = '0;

   radar_frame_tlv_deframer_top #(.LENGTH_WIDTH(LEN_W)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_link_byte      (req_link_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_tlv_count      (rsp_tlv_count),
      .rsp_object_count   (rsp_object_count),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_record_type    (rsp_record_type),
      .rsp_record_length  (rsp_record_length),
      .rsp_record_offset  (rsp_record_offset),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_record (rsp_last_of_record),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_frame_len  (csr_max_frame_len)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   task automatic add_res(input logic [2:0] ev, input logic [31:0] rtype,
                          input logic [31:0] rlen, input logic [15:0] off,
                          input logic [7:0] pbyte, input logic last);
      rsp_item_type r;
      r.event_res      = ev;
      r.frame_number   = st_hdr[1];
      r.tlv_count      = st_hdr[3];
      r.object_count   = st_hdr[2];
      r.packet_length  = st_hdr[0];
      r.record_type    = rtype;
      r.record_length  = rlen;
      r.record_offset  = off;
      r.payload_byte   = pbyte;
      r.last_of_record = last;
      r.end_of_frame   = 1'b0;
      r.last_of_run    = 1'b0;
      step_res.push_back(r);
   endtask

   task automatic drop_rest();
      if (st_pay_left != 0) st_phase = PH_SKIP;
      else st_phase = PH_HUNT;
   endtask

   task automatic advance_payload();
      st_pay_left = st_pay_left - 1'b1;
      st_pay_pos  = st_pay_pos + 1'b1;
   endtask

   task automatic open_record();
      if (st_recs_left != 0 && st_pay_left >= REC_HDR_BYTES) begin
         st_phase   = PH_RHDR;
         st_count   = '0;
         st_rec_hdr = '0;
      end else begin
         if (st_recs_left != 0) add_res(EV_HDR_OVRUN, '0, '0, st_pay_pos, 8'd0, 1'b0);
         drop_rest();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic         eof;
      int           w;
      logic [31:0]  pkt, rtype, rlen, pad;
      logic [15:0]  off;
      logic         last;
      rsp_item_type r;
      eof   = 1'b0;
      w     = -1;
      rtype = st_rec_hdr[31:0];
      rlen  = st_rec_hdr[63:32];
      case (st_phase)
         PH_HUNT: begin
            if (b == SYNC_FIRST) begin
               st_phase    = PH_MAGIC;
               st_count    = 6'd1;
               st_mismatch = 1'b0;
            end
         end
         PH_MAGIC: begin
            if (b != SYNC_WORD[8*st_count[2:0] +: 8]) st_mismatch = 1'b1;
            st_count = st_count + 6'd1;
            if (st_count >= 6'd8) begin
               if (st_mismatch) st_phase = PH_HUNT;
               else st_phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (st_count >= 12 && st_count < 16) w = 0;
            else if (st_count >= 20 && st_count < 24) w = 1;
            else if (st_count >= 28 && st_count < 32) w = 2;
            else if (st_count >= 32 && st_count < 36) w = 3;
            if (w >= 0) st_hdr[w][8*st_count[1:0] +: 8] = b;
            st_count = st_count + 6'd1;
            if (st_count >= HDR_BYTES) begin
               pkt = st_hdr[0];
               if (pkt < 32'(HDR_BYTES) || pkt > 32'(len_limit) ||
                   pkt - 32'(HDR_BYTES) > 32'((64'd1 << LEN_W) - 1)) begin
                  add_res(EV_BAD_LEN, '0, '0, '0, 8'd0, 1'b0);
                  st_phase = PH_HUNT;
               end else begin
                  add_res(EV_FRAME_HDR, '0, '0, '0, 8'd0, 1'b0);
                  st_pay_left  = LEN_W'(pkt - 32'(HDR_BYTES));
                  st_pay_pos   = '0;
                  st_recs_left = st_hdr[3];
                  eof = (st_pay_left == 0);
                  open_record();
               end
            end
         end
         PH_RHDR: begin
            st_rec_hdr[8*st_count[2:0] +: 8] = b;
            st_count = st_count + 6'd1;
            advance_payload();
            if (st_count >= 6'd8) begin
               rtype = st_rec_hdr[31:0];
               rlen  = st_rec_hdr[63:32];
               st_recs_left = st_recs_left - 1;
               add_res(EV_TLV_HDR, rtype, rlen, st_pay_pos, 8'd0, 1'b0);
               if (rlen > 32'(st_pay_left)) begin
                  add_res(EV_PAY_OVRUN, rtype, rlen, st_pay_pos, 8'd0, 1'b0);
                  drop_rest();
               end else if (rlen == 0) begin
                  st_pad_left = '0;
                  open_record();
               end else begin
                  st_rec_left = rlen;
                  st_phase    = PH_RPAY;
               end
            end
            eof = (st_pay_left == 0);
         end
         PH_RPAY: begin
            off = st_pay_pos;
            advance_payload();
            st_rec_left = st_rec_left - 1;
            last = (st_rec_left == 0);
            add_res(EV_PAYLOAD, rtype, rlen, off, b, last);
            if (last) begin
               // padding never runs past the end of the frame
               pad = (32'd0 - rlen) & 32'd3;
               if (pad > 32'(st_pay_left)) pad = 32'(st_pay_left);
               st_pad_left = pad[1:0];
               if (st_pad_left != 0) st_phase = PH_RPAD;
               else open_record();
            end else if (st_pay_left == 0) begin
               st_phase = PH_HUNT;
            end
            eof = (st_pay_left == 0);
         end
         PH_RPAD: begin
            advance_payload();
            st_pad_left = st_pad_left - 2'd1;
            if (st_pad_left == 0 || st_pay_left == 0) begin
               st_pad_left = '0;
               open_record();
            end
            eof = (st_pay_left == 0);
         end
         PH_SKIP: begin
            advance_payload();
            if (st_pay_left == 0) st_phase = PH_HUNT;
            eof = (st_pay_left == 0);
         end
         default: st_phase = PH_HUNT;
      endcase
      foreach (step_res[i]) begin
         r = step_res[i];
         if (eof && r.event_res != EV_BAD_LEN) r.end_of_frame = 1'b1;
         if (i == step_res.size() - 1) r.last_of_run = 1'b1;
         result_q.push_back(r);
      end
      step_res.delete();
   endtask

   // ------------------------------------------------------------------------
   // driver and monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) deframe_byte(req_link_byte);
         if (!req_valid || req_ready) begin
            if (link_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_link_byte <= link_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (result_q.size() == 0) begin
         $display("%0t: result with none predicted, event %0d, expected nothing, got offset %0h",
                  $time, rsp_event_res, rsp_record_offset);
         errors++;
      end else begin
         want = result_q.pop_front();
         check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
         check_field("frame_number", want.frame_number, rsp_frame_number);
         check_field("tlv_count", want.tlv_count, rsp_tlv_count);
         check_field("object_count", want.object_count, rsp_object_count);
         check_field("packet_length", want.packet_length, rsp_packet_length);
         check_field("record_type", want.record_type, rsp_record_type);
         check_field("record_length", want.record_length, rsp_record_length);
         check_field("record_offset", 32'(want.record_offset), 32'(rsp_record_offset));
         check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
         check_field("last_of_record", 32'(want.last_of_record), 32'(rsp_last_of_record));
         check_field("end_of_frame", 32'(want.end_of_frame), 32'(rsp_end_of_frame));
         check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (hold_on) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // long receiver hold in the pressure phase, sender keeps going
   initial begin
      wait (cur_phase == PRESSURE_PH);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      link_q.push_back(b);
      queued++;
   endtask

   task automatic add_junk(input int n);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_rec_hdr(input logic [31:0] rtype, input logic [31:0] rlen);
      for (int i = 0; i < 4; i++) body.push_back(rtype[8*i +: 8]);
      for (int i = 0; i < 4; i++) body.push_back(rlen[8*i +: 8]);
   endtask

   // header, payload (capped, the frame gets cut anyway) and padding
   task automatic add_record(input logic [31:0] rtype, input logic [31:0] rlen);
      add_rec_hdr(rtype, rlen);
      add_junk((rlen > 96) ? 96 : int'(rlen));
      add_junk(int'((32'd0 - rlen) & 32'd3));
   endtask

   // sync word and 32 header bytes (40 in all), then whatever is in body
   task automatic queue_frame(input logic [31:0] pkt, input logic [31:0] fnum,
                              input logic [31:0] objs, input logic [31:0] tlvs);
      logic [31:0] words [8];
      words = '{$urandom(), pkt, $urandom(), fnum, $urandom(), objs, tlvs, $urandom()};
      for (int i = 0; i < 8; i++) push_byte(SYNC_WORD[8*i +: 8]);
      foreach (words[j])
         for (int i = 0; i < 4; i++) push_byte(words[j][8*i +: 8]);
      foreach (body[i]) push_byte(body[i]);
      body.delete();
   endtask

   task automatic build_body(input int plen, input int rec_cap);
      logic [31:0] rlen;
      body.delete();
      body_recs = 0;
      while (body.size() < plen) begin
         if (body_recs < rec_cap) begin
            case ($urandom_range(9))
               0: rlen = 32'd0;
               1: rlen = $urandom();
               2: rlen = $urandom_range(13, 80);
               default: rlen = $urandom_range(1, 12);
            endcase
            add_record($urandom(), rlen);
            body_recs++;
         end else begin
            add_junk(1);
         end
      end
      while (body.size() > plen) void'(body.pop_back());
   endtask

   task automatic random_frame();
      logic [31:0] pkt, tlvs;
      int          room;
      if (len_limit >= 16'd40 && $urandom_range(99) < 85) begin
         room = int'(len_limit) - 40;
         if (room > 48) room = 48;
         build_body($urandom_range(0, room), $urandom_range(0, 6));
         pkt = 32'd40 + body.size();
         case ($urandom_range(9))
            0: tlvs = body_recs + $urandom_range(1, 3);
            1: tlvs = (body_recs > 0) ? body_recs - 1 : 0;
            2: tlvs = $urandom();
            default: tlvs = body_recs;
         endcase
      end else begin
         body.delete();
         case ($urandom_range(2))
            0: pkt = $urandom_range(0, 39);
            1: pkt = 32'(len_limit) + $urandom_range(1, 200);
            default: pkt = $urandom();
         endcase
         tlvs = $urandom();
      end
      queue_frame(pkt, $urandom(), $urandom(), tlvs);
   endtask

   task automatic random_sequence();
      int r, k;
      r = $urandom_range(99);
      if (r < 8) begin
         k = $urandom_range(1, 6);
         for (int i = 0; i < k; i++) push_byte(8'($urandom_range(255)));
      end else if (r < 14) begin
         // sync word with one corrupted byte
         k = $urandom_range(0, 7);
         for (int i = 0; i < 8; i++)
            push_byte((i == k) ? SYNC_WORD[8*i +: 8] ^ 8'($urandom_range(1, 255))
                               : SYNC_WORD[8*i +: 8]);
      end else begin
         random_frame();
      end
   endtask

   task automatic run_directed();
      push_byte(8'hFF);
      push_byte(8'h00);
      for (int i = 0; i < 7; i++) push_byte(SYNC_WORD[8*i +: 8]);
      push_byte(8'h00);
      body.delete();
      queue_frame(32'd40, 32'd0, 32'd0, 32'd0);
      queue_frame(32'd40, '1, '1, 32'd1);            // record due, no room left
      queue_frame(32'd39, 32'd1, 32'd0, 32'd0);
      queue_frame(32'd16385, 32'd2, 32'd0, 32'd1);
      queue_frame('1, 32'd3, 32'd0, 32'd1);
      // padded record, empty record, aligned record ending the frame
      add_rec_hdr(32'd0, 32'd5);
      body.push_back(8'h00);
      body.push_back(8'hFF);
      body.push_back(8'h55);
      body.push_back(8'hAA);
      body.push_back(8'h01);
      add_junk(3);
      add_rec_hdr('1, 32'd0);
      add_record(32'h1234_5678, 32'd8);
      queue_frame(32'd40 + body.size(), 32'h8000_0001, 32'd7, 32'd3);
      // record longer than what is left, then skipped tail
      add_rec_hdr(32'hA5A5_0001, 32'd100);
      add_junk(12);
      queue_frame(32'd60, 32'd10, 32'd1, 32'd1);
      // overrun with nothing left to skip
      add_rec_hdr(32'hA5A5_0002, 32'd4);
      queue_frame(32'd48, 32'd11, 32'd1, 32'd1);
      // second header does not fit
      add_record(32'hA5A5_0003, 32'd4);
      add_junk(4);
      queue_frame(32'd56, 32'd12, 32'd2, 32'd3);
      // padding cut to one byte, then to none
      add_rec_hdr(32'hA5A5_0004, 32'd1);
      add_junk(2);
      queue_frame(32'd50, 32'd13, 32'd0, 32'd1);
      add_rec_hdr(32'hA5A5_0005, 32'd1);
      add_junk(1);
      queue_frame(32'd49, 32'd14, 32'd0, 32'd1);
      // all records done, rest of payload ignored
      add_record(32'hA5A5_0006, 32'd4);
      add_junk(8);
      queue_frame(32'd60, 32'd15, 32'd3, 32'd1);
   endtask

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   task automatic wait_drained();
      while (link_q.size() != 0 || req_valid || result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [15:0] v);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_max_frame_len <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      len_limit = v;
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_limit(PH_LIMIT[p]);
         send_idle_pct = PH_SEND_IDLE[p];
         stall_pct     = PH_STALL[p];
         cur_phase     = p;
         target = queued + PH_BYTES[p];
         while (queued < target) random_sequence();
         wait_drained();
      end
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("testbench NOT OK");
      $finish;
   end

endmodule

[filelist.f]
rtl/rfd_pkg.sv
rtl/rfd_core.sv
rtl/rfd_rsp_queue.sv
rtl/radar_frame_tlv_deframer_top.sv
verif/radar_frame_tlv_deframer_tb.sv
